// File: src/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// Types, sizes and register codes shared by the 3x3 median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int PIX_W        = 8;
    localparam int SIZE_W       = 11;
    localparam int OUT_COORD_W  = 10;
    localparam int WIN_DIM      = 3;
    localparam int WIN_N        = WIN_DIM * WIN_DIM;
    localparam int WIN_MID      = WIN_N / 2;
    localparam int WIN_HIST     = WIN_N - WIN_DIM;
    localparam int WIN_EDGE     = WIN_DIM - 1;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_A        = (ROW_W > COL_W + 1) ? ROW_W : COL_W + 1;
    localparam int CMP_W        = (CMP_A > SIZE_W) ? CMP_A : SIZE_W;
    localparam int WIN_IDX_W    = $clog2(WIN_N);
    localparam int CFG_IDX_W    = 1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] win_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'd0,
        REG_IMAGE_HEIGHT = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } size_cfg_t;

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } pix_in_t;

    typedef struct packed {
        pix_t                   median_value;
        logic [OUT_COORD_W-1:0] centre_row;
        logic [OUT_COORD_W-1:0] centre_col;
        logic                   frame_last;
    } med_out_t;

    typedef struct packed {
        win_t                   pix;
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic                   last;
    } win_item_t;

endpackage

// File: src/mf_stream_if.sv
// ----------------------------------------------------------------------------
// mf_stream_if
// Valid/ready stream interfaces for pixels in and median results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mf_pixel_if import mf_pkg::*; ();
    logic    valid;
    logic    ready;
    pix_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mf_median_if import mf_pkg::*; ();
    logic     valid;
    logic     ready;
    med_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// 3x3 median filter over a raster pixel stream with two line stores in RAM.
// Throughput: one pixel per clock; a stalled result output holds the pipeline.
// Each result passes the line-store, window and median registers in turn.
// The throughput rests on one line-store read and one write per cycle.
// Reset clears position, window and pipeline; line stores are not cleared.
// Size registers reset to 1024 by 1024.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_filter_3x3_top import mf_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    mf_pixel_if.sink             pixel_stream,
    mf_median_if.source          median_stream
);

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                     logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(WIN_DIM))
        begin
            r = SIZE_W'(WIN_DIM);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    size_cfg_t size_reg;
    logic      advance, accept;
    logic      win_valid, med_valid;
    win_item_t win_item;
    med_out_t  med_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg.width  <= SIZE_W'(MAX_WIDTH);
            size_reg.height <= SIZE_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    size_reg.width <= clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT:
                begin
                    size_reg.height <= clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));
                end
                default:
                begin
                    size_reg <= size_reg;
                end
            endcase
        end
    end

    assign advance            = !med_valid || median_stream.ready;
    assign accept             = pixel_stream.valid && advance;
    assign pixel_stream.ready = advance;

    mf_linebuf u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pix       (pixel_stream.data),
        .size      (size_reg),
        .advance   (advance),
        .win_valid (win_valid),
        .win_item  (win_item)
    );

    mf_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (win_valid),
        .in_item   (win_item),
        .out_valid (med_valid),
        .out_item  (med_item)
    );

    assign median_stream.valid = med_valid;
    assign median_stream.data  = med_item;

endmodule

// File: src/mf_ram.sv
// ----------------------------------------------------------------------------
// mf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mf_linebuf.sv
// ----------------------------------------------------------------------------
// mf_linebuf
// Raster position tracking, the two line stores and the 3x3 window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_linebuf import mf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  pix_in_t   pix,
    input  size_cfg_t size,
    input  logic      advance,
    output logic      win_valid,
    output win_item_t win_item
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W-1:0] col_s, col_a;
    logic [ROW_W-1:0] row_s, row_a;
    logic [CMP_W-1:0] w_c, h_c, col_sc, col_ac, row_ac, col_inc, row_dec, col_dec;
    logic             wrap_s, wrap_n, live, emit, last, load;

    logic                   b_valid_reg;
    pix_t                   b_px_reg;
    logic [COL_W-1:0]       b_col_reg;
    logic                   b_emit_reg;
    logic [OUT_COORD_W-1:0] b_row_out_reg, b_col_out_reg;
    logic                   b_last_reg;
    logic                   fwd_hit_reg;
    pix_t                   fwd_top_reg, fwd_mid_reg;

    pix_t upper_q, middle_q, top_b, mid_b;
    logic b_write;

    pix_t win_reg [WIN_HIST];

    logic      win_valid_reg;
    win_item_t win_item_reg;

    always_comb
    begin
        w_c     = CMP_W'(size.width);
        h_c     = CMP_W'(size.height);
        row_s   = pix.frame_start ? '0 : row_reg;
        col_s   = pix.frame_start ? '0 : col_reg;
        col_sc  = CMP_W'(col_s);
        wrap_s  = col_sc >= w_c;
        col_a   = wrap_s ? '0 : col_s;
        row_a   = wrap_s ? row_s + 1'b1 : row_s;
        col_ac  = CMP_W'(col_a);
        row_ac  = CMP_W'(row_a);
        live    = row_ac < h_c;
        emit    = (row_ac >= CMP_W'(WIN_EDGE)) && (col_ac >= CMP_W'(WIN_EDGE));
        last    = (row_ac == h_c - 1'b1) && (col_ac == w_c - 1'b1);
        col_inc = col_ac + 1'b1;
        wrap_n  = col_inc >= w_c;
        row_dec = row_ac - 1'b1;
        col_dec = col_ac - 1'b1;
        load    = accept && live;

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (!live)
            begin
                row_next = row_a;
                col_next = col_a;
            end
            else if (wrap_n)
            begin
                row_next = row_a + 1'b1;
                col_next = '0;
            end
            else
            begin
                row_next = row_a;
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign b_write = advance && b_valid_reg;
    assign top_b   = fwd_hit_reg ? fwd_top_reg : upper_q;
    assign mid_b   = fwd_hit_reg ? fwd_mid_reg : middle_q;

    mf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (b_write),
        .waddr (b_col_reg),
        .wdata (mid_b),
        .re    (load),
        .raddr (col_a),
        .rdata (upper_q)
    );

    mf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (b_write),
        .waddr (b_col_reg),
        .wdata (b_px_reg),
        .re    (load),
        .raddr (col_a),
        .rdata (middle_q)
    );

    // A read of the column that the previous transaction writes in the same
    // cycle takes the new data from the forwarding registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            b_px_reg      <= pix.pixel;
            b_col_reg     <= col_a;
            b_emit_reg    <= emit;
            b_row_out_reg <= row_dec[OUT_COORD_W-1:0];
            b_col_out_reg <= col_dec[OUT_COORD_W-1:0];
            b_last_reg    <= last;
            fwd_hit_reg   <= b_valid_reg && (b_col_reg == col_a);
            fwd_top_reg   <= mid_b;
            fwd_mid_reg   <= b_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_HIST; i++)
            begin
                win_reg[i] <= '0;
            end
            win_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            win_valid_reg <= b_valid_reg && b_emit_reg;
            if (b_valid_reg)
            begin
                for (int i = 0; i < WIN_HIST - WIN_DIM; i++)
                begin
                    win_reg[i] <= win_reg[i + WIN_DIM];
                end
                win_reg[WIN_HIST - WIN_DIM]     <= top_b;
                win_reg[WIN_HIST - WIN_DIM + 1] <= mid_b;
                win_reg[WIN_HIST - WIN_DIM + 2] <= b_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg && b_emit_reg)
        begin
            for (int i = 0; i < WIN_HIST; i++)
            begin
                win_item_reg.pix[i] <= win_reg[i];
            end
            win_item_reg.pix[WIN_HIST]     <= top_b;
            win_item_reg.pix[WIN_HIST + 1] <= mid_b;
            win_item_reg.pix[WIN_HIST + 2] <= b_px_reg;
            win_item_reg.row               <= b_row_out_reg;
            win_item_reg.col               <= b_col_out_reg;
            win_item_reg.last              <= b_last_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_item  = win_item_reg;

endmodule

// File: src/mf_median.sv
// ----------------------------------------------------------------------------
// mf_median
// Two-stage pipelined median-of-nine compare-exchange network.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_median import mf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  win_item_t in_item,
    output logic      out_valid,
    output med_out_t  out_item
);

    function automatic win_t cx(win_t a, logic [WIN_IDX_W-1:0] i, logic [WIN_IDX_W-1:0] j);
        win_t r;
        pix_t t;
        r = a;
        if (r[i] > r[j])
        begin
            t    = r[i];
            r[i] = r[j];
            r[j] = t;
        end
        return r;
    endfunction

    win_t      v1, v2;
    win_item_t d_item_reg;
    logic      d_valid_reg;
    med_out_t  out_reg;
    logic      out_valid_reg;

    always_comb
    begin
        v1 = in_item.pix;
        v1 = cx(v1, 4'd1, 4'd2);
        v1 = cx(v1, 4'd4, 4'd5);
        v1 = cx(v1, 4'd7, 4'd8);
        v1 = cx(v1, 4'd0, 4'd1);
        v1 = cx(v1, 4'd3, 4'd4);
        v1 = cx(v1, 4'd6, 4'd7);
        v1 = cx(v1, 4'd1, 4'd2);
        v1 = cx(v1, 4'd4, 4'd5);
        v1 = cx(v1, 4'd7, 4'd8);
        v1 = cx(v1, 4'd0, 4'd3);
        v1 = cx(v1, 4'd5, 4'd8);
        v1 = cx(v1, 4'd4, 4'd7);
        v1 = cx(v1, 4'd3, 4'd6);
        v1 = cx(v1, 4'd1, 4'd4);
        v1 = cx(v1, 4'd2, 4'd5);
    end

    always_comb
    begin
        v2 = d_item_reg.pix;
        v2 = cx(v2, 4'd4, 4'd7);
        v2 = cx(v2, 4'd2, 4'd4);
        v2 = cx(v2, 4'd4, 4'd6);
        v2 = cx(v2, 4'd2, 4'd4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            d_valid_reg   <= in_valid;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            d_item_reg.pix  <= v1;
            d_item_reg.row  <= in_item.row;
            d_item_reg.col  <= in_item.col;
            d_item_reg.last <= in_item.last;
        end
        if (advance && d_valid_reg)
        begin
            out_reg.median_value <= v2[WIN_MID];
            out_reg.centre_row   <= d_item_reg.row;
            out_reg.centre_col   <= d_item_reg.col;
            out_reg.frame_last   <= d_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: src/mf_checker.sv
// ----------------------------------------------------------------------------
// mf_checker
// Port-level checks on the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_checker import mf_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input med_out_t out_data
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready although no result is pending");

    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.centre_row != '0) && (out_data.centre_col != '0))
        else $error("result centre lies on the image border");

endmodule

bind median_filter_3x3_top mf_checker u_mf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixel_stream.ready),
    .out_valid (median_stream.valid),
    .out_ready (median_stream.ready),
    .out_data  (median_stream.data)
);

// File: tb/median_filter_3x3_top_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top_tb
// Self-checking testbench for the 3x3 median filter. Pixel transactions are
// sent through the valid/ready input stream while both sides stall at random.
// A behavioral line-store and window model predicts every median transaction,
// which is then compared field by field with what the filter delivers. The
// tests cover minimum and maximum image sizes, size clamping, a mid-frame
// width reduction, frame restarts, pixels past the frame end and random frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_filter_3x3_top_tb;
    import mf_pkg::*;

    localparam int          RANDOM_PIXELS = 700;
    localparam int          WIDE_EXTRA    = 8;
    localparam int          TALL_ROWS     = 20;
    localparam int          PIPE_SLACK    = 8;
    localparam longint      RUN_LIMIT_NS  = 5_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    mf_pixel_if  pixel_stream ();
    mf_median_if median_stream ();

    median_filter_3x3_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_stream  (pixel_stream),
        .median_stream (median_stream)
    );

    pix_t              upper_line [MAX_WIDTH];
    pix_t              middle_line [MAX_WIDTH];
    pix_t              column_hist [WIN_HIST];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    med_out_t          pending_medians [$];
    med_out_t          seen_median;
    med_out_t          want_median;
    int unsigned       mismatches;
    int unsigned       taken_pixels;
    bit                steady;

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] raw,
                                               input int unsigned top);
        if (raw < WIN_DIM)
            return WIN_DIM;
        if (raw > top)
            return top;
        return raw;
    endfunction

    function automatic pix_t median_of(input win_t win);
        int less;
        int same;
        pix_t found;
        found = win[0];
        for (int i = 0; i < WIN_N; i++)
        begin
            less = 0;
            same = 0;
            for (int j = 0; j < WIN_N; j++)
            begin
                if (win[j] < win[i])
                    less++;
                else if (win[j] == win[i])
                    same++;
            end
            if (less <= WIN_MID && less + same > WIN_MID)
                found = win[i];
        end
        return found;
    endfunction

    task automatic advance_filter(input pix_t px, input logic first, output bit taken,
                                  output bit produced, output med_out_t result);
        int unsigned w;
        int unsigned h;
        pix_t top;
        pix_t mid;
        win_t win;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        taken = 1'b0;
        produced = 1'b0;
        result = '0;
        if (first)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos < h)
        begin
            taken = 1'b1;
            top = upper_line[col_pos];
            mid = middle_line[col_pos];
            upper_line[col_pos] = mid;
            middle_line[col_pos] = px;
            if (row_pos >= WIN_EDGE && col_pos >= WIN_EDGE)
            begin
                for (int i = 0; i < WIN_HIST; i++)
                    win[i] = column_hist[i];
                win[WIN_HIST] = top;
                win[WIN_HIST + 1] = mid;
                win[WIN_HIST + 2] = px;
                result.median_value = median_of(win);
                result.centre_row = OUT_COORD_W'(row_pos - 1);
                result.centre_col = OUT_COORD_W'(col_pos - 1);
                result.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
                produced = 1'b1;
            end
            for (int i = 0; i < WIN_HIST - WIN_DIM; i++)
                column_hist[i] = column_hist[i + WIN_DIM];
            column_hist[WIN_HIST - 3] = top;
            column_hist[WIN_HIST - 2] = mid;
            column_hist[WIN_HIST - 1] = px;
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    task automatic send_pixel(input pix_t value, input logic first);
        bit taken;
        bit produced;
        med_out_t result;
        pix_in_t item;
        pix_in_t junk;
        item.pixel = value;
        item.frame_start = first;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            junk.pixel = pix_t'($urandom);
            junk.frame_start = ($urandom_range(0, 1) != 0);
            pixel_stream.valid <= 1'b0;
            pixel_stream.data <= junk;
            @(negedge clk);
        end
        pixel_stream.valid <= 1'b1;
        pixel_stream.data <= item;
        @(posedge clk);
        while (!pixel_stream.ready)
            @(posedge clk);
        advance_filter(value, first, taken, produced, result);
        if (taken)
            taken_pixels++;
        if (produced)
            pending_medians.push_back(result);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pixel_stream.valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(negedge clk);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    function automatic pix_t pick_pixel(input int unsigned style, input pix_t base);
        case (style)
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return base + pix_t'($urandom_range(0, 3));
            default: return pix_t'($urandom);
        endcase
    endfunction

    task automatic test_small_frames();
        pix_t frame_a [9];
        pix_t frame_b [9];
        frame_a = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        frame_b = '{8'd200, 8'd1, 8'd128, 8'd127, 8'd255, 8'd0, 8'd64, 8'd190, 8'd2};
        write_sizes(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(frame_a[i], i == 0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b0);
        for (int i = 0; i < 9; i++)
            send_pixel(frame_b[i], i == 0);
        wait_drained();
    endtask

    task automatic test_width_shrink();
        write_sizes(11'd8, 11'd6);
        for (int i = 0; i < 22; i++)
            send_pixel(pix_t'($urandom), i == 0);
        wait_drained();
        write_sizes(11'd4, 11'd6);
        for (int i = 0; i < 14; i++)
            send_pixel(pix_t'($urandom), 1'b0);
        wait_drained();
    endtask

    task automatic test_widest_frame();
        steady = 1'b1;
        write_sizes(11'h7FF, 11'd3);
        for (int i = 0; i < MAX_WIDTH + WIDE_EXTRA; i++)
            send_pixel(pix_t'($urandom), i == 0);
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_tallest_frame();
        write_sizes(11'd3, 11'h7FF);
        for (int i = 0; i < WIN_DIM * TALL_ROWS; i++)
            send_pixel(pix_t'($urandom), i == 0);
        send_pixel(pix_t'($urandom), 1'b0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned start_count;
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned frame_len;
        int unsigned frames;
        int unsigned style;
        pix_t base;
        logic first;
        start_count = taken_pixels;
        while (taken_pixels - start_count < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0: w_raw = SIZE_W'($urandom_range(0, 2));
                1: w_raw = SIZE_W'($urandom_range(13, 40));
                default: w_raw = SIZE_W'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 11))
                0: h_raw = SIZE_W'($urandom_range(0, 2));
                1: h_raw = SIZE_W'($urandom_range(MAX_HEIGHT + 1, 2047));
                default: h_raw = SIZE_W'($urandom_range(3, 10));
            endcase
            eff_w = clamp_size(w_raw, MAX_WIDTH);
            eff_h = clamp_size(h_raw, MAX_HEIGHT);
            frame_len = (eff_h > 10) ? eff_w * 8 : eff_w * eff_h;
            write_sizes(w_raw, h_raw);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                style = $urandom_range(0, 3);
                base = pix_t'($urandom_range(0, 252));
                for (int i = 0; i < frame_len; i++)
                begin
                    if (i == 0)
                        first = (f == 0) || ($urandom_range(0, 19) != 0);
                    else
                        first = ($urandom_range(0, 59) == 0);
                    send_pixel(pick_pixel(style, base), first);
                end
                repeat ($urandom_range(0, 2))
                    send_pixel(pix_t'($urandom), 1'b0);
            end
            wait_drained();
        end
    endtask

    always @(negedge clk)
        median_stream.ready <= steady || ($urandom_range(0, 99) >= 25);

    always @(posedge clk)
    begin
        if (rst_n && median_stream.valid && median_stream.ready)
        begin
            seen_median = median_stream.data;
            if (pending_medians.size() == 0)
                report_mismatch("median_value with no transaction pending",
                                seen_median.median_value, 0);
            else
            begin
                want_median = pending_medians.pop_front();
                if (seen_median.median_value !== want_median.median_value)
                    report_mismatch("median_value", seen_median.median_value,
                                    want_median.median_value);
                if (seen_median.centre_row !== want_median.centre_row)
                    report_mismatch("centre_row", seen_median.centre_row,
                                    want_median.centre_row);
                if (seen_median.centre_col !== want_median.centre_col)
                    report_mismatch("centre_col", seen_median.centre_col,
                                    want_median.centre_col);
                if (seen_median.frame_last !== want_median.frame_last)
                    report_mismatch("frame_last", seen_median.frame_last,
                                    want_median.frame_last);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL median_filter_3x3_top");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        pixel_stream.valid = 1'b0;
        pixel_stream.data = '0;
        steady = 1'b0;
        mismatches = 0;
        taken_pixels = 0;
        width_reg = SIZE_W'(MAX_WIDTH);
        height_reg = SIZE_W'(MAX_HEIGHT);
        row_pos = 0;
        col_pos = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < WIN_HIST; i++)
            column_hist[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_small_frames();
        test_width_shrink();
        test_widest_frame();
        test_tallest_frame();
        test_random_frames();
        wait_drained();
        if (mismatches == 0)
            $display("PASS median_filter_3x3_top");
        else
            $display("FAIL median_filter_3x3_top");
        $finish;
    end

endmodule
